[rtl/met_pkg.sv]
// shared constants, types and functions of the escape-time pixel engine
package met_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int CW         = 32;
    localparam int PW         = 11;
    localparam int NW         = 11;
    localparam int STEP_W     = 31;
    localparam int ER_W       = 3;
    localparam int R2_W       = 2 * ER_W;
    localparam int PROD_W     = PW + STEP_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int MAG_W      = 2 * CW;
    localparam int SEQ_W      = 2;
    localparam int ITER_LIMIT = 1024;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_RE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_IM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_RAD  = 3'd4;

    typedef struct packed {
        logic [PW-1:0]        col;
        logic [PW-1:0]        row;
        logic signed [CW-1:0] cr;
        logic signed [CW-1:0] ci;
    } point_t;

    typedef struct packed {
        logic                 valid;
        logic                 done;
        logic                 in_set;
        logic [SEQ_W-1:0]     seq;
        logic [PW-1:0]        col;
        logic [PW-1:0]        row;
        logic signed [CW-1:0] cr;
        logic signed [CW-1:0] ci;
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic [NW-1:0]        n;
    } slot_t;

    typedef struct packed {
        logic [PW-1:0] col;
        logic [PW-1:0] row;
        logic          in_set;
        logic [NW-1:0] n;
    } res_t;

    function automatic logic signed [CW-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(CW-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            sat32 = {1'b0, {(CW-1){1'b1}}};
        end else if (v < lo) begin
            sat32 = {1'b1, {(CW-1){1'b0}}};
        end else begin
            sat32 = v[CW-1:0];
        end
    endfunction

endpackage

[rtl/met_cgen.sv]
// two-stage pipeline that maps a pixel position to its complex point c
module met_cgen (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [met_pkg::PW-1:0]            s_col,
    input  logic [met_pkg::PW-1:0]            s_row,
    input  logic signed [met_pkg::CW-1:0]     min_re,
    input  logic signed [met_pkg::CW-1:0]     max_im,
    input  logic [met_pkg::STEP_W-1:0]        step,
    output logic                              p_valid,
    input  logic                              p_ready,
    output met_pkg::point_t                   p_data
);

    logic                          v1_reg;
    logic [met_pkg::PW-1:0]        col1_reg;
    logic [met_pkg::PW-1:0]        row1_reg;
    logic [met_pkg::PROD_W-1:0]    pc_reg;
    logic [met_pkg::PROD_W-1:0]    pr_reg;
    logic                          v2_reg;
    met_pkg::point_t               pt2_reg;
    logic                          adv2;
    logic                          adv1;
    logic signed [met_pkg::SUM_W-1:0] re_sum;
    logic signed [met_pkg::SUM_W-1:0] im_sum;

    assign adv2    = !v2_reg || p_ready;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;
    assign p_valid = v2_reg;
    assign p_data  = pt2_reg;

    assign re_sum = met_pkg::SUM_W'(min_re) + $signed({2'b00, pc_reg});
    assign im_sum = met_pkg::SUM_W'(max_im) - $signed({2'b00, pr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg   <= s_valid;
                col1_reg <= s_col;
                row1_reg <= s_row;
                pc_reg   <= met_pkg::PROD_W'(s_col) * met_pkg::PROD_W'(step);
                pr_reg   <= met_pkg::PROD_W'(s_row) * met_pkg::PROD_W'(step);
            end
            if (adv2) begin
                v2_reg      <= v1_reg;
                pt2_reg.col <= col1_reg;
                pt2_reg.row <= row1_reg;
                pt2_reg.cr  <= met_pkg::sat32(re_sum);
                pt2_reg.ci  <= met_pkg::sat32(im_sum);
            end
        end
    end

endmodule

[rtl/met_ring.sv]
// three-stage recirculating iteration pipeline, pixels leave in arrival order
module met_ring (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          p_valid,
    output logic                          p_ready,
    input  met_pkg::point_t               p_data,
    input  logic [met_pkg::NW-1:0]        lim,
    input  logic [met_pkg::R2_W-1:0]      r2t,
    output logic                          r_valid,
    input  logic                          r_ready,
    output met_pkg::res_t                 r_data
);

    localparam int SH2 = 2 * met_pkg::FRAC_BITS;
    localparam int DW  = met_pkg::MAG_W - met_pkg::FRAC_BITS;
    localparam int BW  = met_pkg::MAG_W - met_pkg::FRAC_BITS + 1;

    met_pkg::slot_t                       head;
    met_pkg::slot_t                       s1_reg;
    met_pkg::slot_t                       s2_reg;
    met_pkg::slot_t                       s3_reg;
    met_pkg::slot_t                       s3_next;
    logic signed [met_pkg::MAG_W-1:0]     aa_reg;
    logic signed [met_pkg::MAG_W-1:0]     bb_reg;
    logic signed [met_pkg::MAG_W-1:0]     ab_reg;
    logic signed [met_pkg::MAG_W-1:0]     dif;
    logic [met_pkg::MAG_W-1:0]            mag_reg;
    logic signed [DW-1:0]                 dsh_reg;
    logic signed [BW-1:0]                 psh_reg;
    logic [met_pkg::SEQ_W-1:0]            in_seq_reg;
    logic [met_pkg::SEQ_W-1:0]            out_seq_reg;
    logic                                 exit_w;
    logic                                 ins_w;
    logic                                 esc;
    logic [met_pkg::MAG_W-1:0]            esc_thr;
    logic [met_pkg::MAG_W-1:0]            in_thr;

    assign exit_w  = s3_reg.valid && s3_reg.done && (s3_reg.seq == out_seq_reg) && r_ready;
    assign ins_w   = p_valid && (!s3_reg.valid || exit_w);
    assign p_ready = !s3_reg.valid || exit_w;
    assign r_valid = s3_reg.valid && s3_reg.done && (s3_reg.seq == out_seq_reg);
    assign r_data  = '{col: s3_reg.col, row: s3_reg.row, in_set: s3_reg.in_set, n: s3_reg.n};

    always_comb begin
        head = s3_reg;
        if (exit_w) begin
            head.valid = 1'b0;
        end
        if (ins_w) begin
            head.valid  = 1'b1;
            head.done   = 1'b0;
            head.in_set = 1'b0;
            head.seq    = in_seq_reg;
            head.col    = p_data.col;
            head.row    = p_data.row;
            head.cr     = p_data.cr;
            head.ci     = p_data.ci;
            head.a      = '0;
            head.b      = '0;
            head.n      = '0;
        end
    end

    assign dif     = aa_reg - bb_reg;
    assign esc_thr = met_pkg::MAG_W'(r2t) << SH2;
    assign in_thr  = met_pkg::MAG_W'(4) << SH2;
    assign esc     = mag_reg > esc_thr;

    always_comb begin
        s3_next = s2_reg;
        if (s2_reg.valid && !s2_reg.done) begin
            if ((s2_reg.n >= lim) || esc) begin
                s3_next.done   = 1'b1;
                s3_next.in_set = mag_reg <= in_thr;
            end else begin
                s3_next.a = met_pkg::sat32(met_pkg::SUM_W'(dsh_reg) + met_pkg::SUM_W'(s2_reg.cr));
                s3_next.b = met_pkg::sat32(met_pkg::SUM_W'(psh_reg) + met_pkg::SUM_W'(s2_reg.ci));
                s3_next.n = s2_reg.n + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
            in_seq_reg   <= '0;
            out_seq_reg  <= '0;
        end else begin
            s1_reg  <= head;
            aa_reg  <= head.a * head.a;
            bb_reg  <= head.b * head.b;
            ab_reg  <= head.a * head.b;
            s2_reg  <= s1_reg;
            mag_reg <= aa_reg + bb_reg;
            dsh_reg <= dif[met_pkg::MAG_W-1:met_pkg::FRAC_BITS];
            psh_reg <= ab_reg[met_pkg::MAG_W-1:met_pkg::FRAC_BITS-1];
            s3_reg  <= s3_next;
            if (ins_w) begin
                in_seq_reg <= in_seq_reg + 1'b1;
            end
            if (exit_w) begin
                out_seq_reg <= out_seq_reg + 1'b1;
            end
        end
    end

    a_n_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_reg.valid |-> (s3_reg.n <= lim))
        else $error("iteration count passed the limit");

    a_done_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_reg.valid && s3_reg.done && !exit_w) |-> ##3 (s3_reg.valid && s3_reg.done))
        else $error("finished pixel lost in the ring");

    a_seq_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        !((s1_reg.valid && s2_reg.valid && s1_reg.seq == s2_reg.seq) ||
          (s1_reg.valid && s3_reg.valid && s1_reg.seq == s3_reg.seq) ||
          (s2_reg.valid && s3_reg.valid && s2_reg.seq == s3_reg.seq)))
        else $error("two pixels share a sequence tag");

endmodule

[rtl/met_color.sv]
// serial color divider and output register of the escape-time engine
module met_color (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          r_valid,
    output logic                          r_ready,
    input  met_pkg::res_t                 r_data,
    input  logic [met_pkg::NW-1:0]        lim,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [met_pkg::PW-1:0]        m_out_col,
    output logic [met_pkg::PW-1:0]        m_out_row,
    output logic                          m_inside_res,
    output logic [met_pkg::NW-1:0]        m_iter_count,
    output logic [met_pkg::COLOR_W-1:0]   m_green,
    output logic [met_pkg::COLOR_W-1:0]   m_blue
);

    localparam int KW    = $clog2(met_pkg::COLOR_W);
    localparam int REM_W = met_pkg::NW + met_pkg::COLOR_W;
    localparam int BL_W  = met_pkg::COLOR_W + 10;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN, ST_OUT} state_t;

    state_t                       state_reg;
    met_pkg::res_t                res_reg;
    logic [REM_W-1:0]             rem_reg;
    logic [met_pkg::COLOR_W-1:0]  q_reg;
    logic [KW-1:0]                k_reg;
    logic [met_pkg::COLOR_W-1:0]  green_reg;
    logic [met_pkg::COLOR_W-1:0]  blue_reg;
    logic [REM_W-1:0]             dsor;
    logic [REM_W-1:0]             dvnd;
    logic [BL_W-1:0]              blue_prod;

    assign r_ready      = state_reg == ST_IDLE;
    assign m_valid      = state_reg == ST_OUT;
    assign m_out_col    = res_reg.col;
    assign m_out_row    = res_reg.row;
    assign m_inside_res = res_reg.in_set;
    assign m_iter_count = res_reg.n;
    assign m_green      = green_reg;
    assign m_blue       = blue_reg;

    assign dsor      = REM_W'(lim) << k_reg;
    assign dvnd      = (REM_W'(r_data.n) << met_pkg::COLOR_W) - REM_W'(r_data.n);
    assign blue_prod = BL_W'(q_reg) * BL_W'(615);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (r_valid) begin
                        res_reg   <= r_data;
                        rem_reg   <= dvnd;
                        q_reg     <= '0;
                        k_reg     <= KW'(met_pkg::COLOR_W - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (rem_reg >= dsor) begin
                        rem_reg      <= rem_reg - dsor;
                        q_reg[k_reg] <= 1'b1;
                    end
                    if (k_reg == '0) begin
                        state_reg <= ST_FIN;
                    end
                    k_reg <= k_reg - 1'b1;
                end
                ST_FIN: begin
                    green_reg <= res_reg.in_set ? '0 : q_reg;
                    state_reg <= ST_OUT;
                    // blue = floor(3*green/5) via 3*205/1024
                    blue_reg  <= res_reg.in_set ? '0 : blue_prod[BL_W-1:10];
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_blue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && $past(state_reg) == ST_OUT) |-> (blue_reg <= 8'd153))
        else $error("blue out of range");

    a_inside_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_inside_res) |-> (m_green == '0))
        else $error("inside pixel has color");

    a_ring_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |=> (state_reg == ST_DIV || state_reg == ST_FIN))
        else $error("divider left early");

endmodule

[rtl/mandelbrot_escape_time_pixel.sv]
// top level of the escape-time pixel engine: config registers and unit wiring
// Each pixel (s_col, s_row) is mapped to c in the coordinate pipeline, then iterates in a three-stage
// ring that holds up to three pixels at once; one iteration is one pass through the ring's stages,
// so several pixels share the ring while each one iterates.
// The color unit divides one bit per cycle and takes a new pixel only once the last one has left
// its output register, which sets the floor of the rate. Results leave in input order.
module mandelbrot_escape_time_pixel (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [met_pkg::PW-1:0]              s_col,
    input  logic [met_pkg::PW-1:0]              s_row,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [met_pkg::PW-1:0]              m_out_col,
    output logic [met_pkg::PW-1:0]              m_out_row,
    output logic                                m_inside_res,
    output logic [met_pkg::NW-1:0]              m_iter_count,
    output logic [met_pkg::COLOR_W-1:0]         m_green,
    output logic [met_pkg::COLOR_W-1:0]         m_blue,
    input  logic                                cfg_we,
    input  logic [met_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [met_pkg::CW-1:0]              cfg_data
);

    logic signed [met_pkg::CW-1:0]    min_re_reg;
    logic signed [met_pkg::CW-1:0]    max_im_reg;
    logic [met_pkg::STEP_W-1:0]       step_reg;
    logic [met_pkg::NW-1:0]           max_iter_reg;
    logic [met_pkg::ER_W-1:0]         esc_rad_reg;
    logic [met_pkg::NW-1:0]           lim;
    logic [met_pkg::R2_W-1:0]         r2t;
    logic                             p_valid;
    logic                             p_ready;
    met_pkg::point_t                  p_data;
    logic                             r_valid;
    logic                             r_ready;
    met_pkg::res_t                    r_data;

    assign lim = (max_iter_reg > met_pkg::NW'(met_pkg::ITER_LIMIT)) ?
                 met_pkg::NW'(met_pkg::ITER_LIMIT) : max_iter_reg;
    assign r2t = met_pkg::R2_W'(esc_rad_reg) * met_pkg::R2_W'(esc_rad_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_re_reg   <= -32'sd402653184;
            max_im_reg   <= 32'sd402653184;
            step_reg     <= 31'd786432;
            max_iter_reg <= 11'd256;
            esc_rad_reg  <= 3'd2;
        end else if (cfg_we) begin
            case (cfg_index)
                met_pkg::REG_MIN_RE:   min_re_reg   <= cfg_data;
                met_pkg::REG_MAX_IM:   max_im_reg   <= cfg_data;
                met_pkg::REG_STEP:     step_reg     <= cfg_data[met_pkg::STEP_W-1:0];
                met_pkg::REG_MAX_ITER: max_iter_reg <= cfg_data[met_pkg::NW-1:0];
                met_pkg::REG_ESC_RAD:  esc_rad_reg  <= cfg_data[met_pkg::ER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    met_cgen u_cgen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_col   (s_col),
        .s_row   (s_row),
        .min_re  (min_re_reg),
        .max_im  (max_im_reg),
        .step    (step_reg),
        .p_valid (p_valid),
        .p_ready (p_ready),
        .p_data  (p_data)
    );

    met_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .p_valid (p_valid),
        .p_ready (p_ready),
        .p_data  (p_data),
        .lim     (lim),
        .r2t     (r2t),
        .r_valid (r_valid),
        .r_ready (r_ready),
        .r_data  (r_data)
    );

    met_color u_color (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .r_valid      (r_valid),
        .r_ready      (r_ready),
        .r_data       (r_data),
        .lim          (lim),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_col    (m_out_col),
        .m_out_row    (m_out_row),
        .m_inside_res (m_inside_res),
        .m_iter_count (m_iter_count),
        .m_green      (m_green),
        .m_blue       (m_blue)
    );

endmodule

[verif/tb_mandelbrot_escape_time_pixel.sv]
// testbench of the escape-time pixel engine: predictor, directed table, random traffic
module tb_mandelbrot_escape_time_pixel;

    typedef struct packed {
        logic [met_pkg::PW-1:0]      col;
        logic [met_pkg::PW-1:0]      row;
        logic                        in_set;
        logic [met_pkg::NW-1:0]      n;
        logic [met_pkg::COLOR_W-1:0] green;
        logic [met_pkg::COLOR_W-1:0] blue;
    } pixel_t;

    typedef struct {
        logic [met_pkg::PW-1:0] col;
        logic [met_pkg::PW-1:0] row;
        bit                     known;
        pixel_t                 res;
    } vec_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [met_pkg::PW-1:0] s_col = '0;
    logic [met_pkg::PW-1:0] s_row = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [met_pkg::PW-1:0] m_out_col;
    logic [met_pkg::PW-1:0] m_out_row;
    logic m_inside_res;
    logic [met_pkg::NW-1:0] m_iter_count;
    logic [met_pkg::COLOR_W-1:0] m_green;
    logic [met_pkg::COLOR_W-1:0] m_blue;
    logic cfg_we = 1'b0;
    logic [met_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [met_pkg::CW-1:0] cfg_data = '0;

    // shadow of the configuration registers
    logic signed [63:0] re0;
    logic signed [63:0] im0;
    logic [63:0] pitch;
    logic [63:0] iter_max;
    logic [63:0] radius;

    pixel_t pending_pixels[$];
    int errors = 0;
    int n_in = 0;
    int n_out = 0;
    int n_inside = 0;
    int idle_pct_s = 0;
    int idle_pct_m = 0;
    int quiet = 0;

    mandelbrot_escape_time_pixel dut (.*);

    always #5 aclk = ~aclk;

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] mag_sq(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
        return a * a + b * b;
    endfunction

    // true when m exceeds t whole units squared
    function automatic bit exceeds(input logic [63:0] m, input logic [63:0] t);
        if (t == 0) return m != 0;
        return (m >> (2 * met_pkg::FRAC_BITS)) > t ||
               ((m >> (2 * met_pkg::FRAC_BITS)) == t && m[2*met_pkg::FRAC_BITS-1:0] != 0);
    endfunction

    function automatic pixel_t escape_pixel(input logic [met_pkg::PW-1:0] col,
                                            input logic [met_pkg::PW-1:0] row);
        logic [63:0] lim;
        logic signed [63:0] cr;
        logic signed [63:0] ci;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] na;
        logic signed [63:0] nb;
        logic [63:0] n;
        logic [63:0] g;
        pixel_t p;
        lim = iter_max > met_pkg::ITER_LIMIT ? met_pkg::ITER_LIMIT : iter_max;
        cr = clamp32(re0 + $signed(64'(col) * pitch));
        ci = clamp32(im0 - $signed(64'(row) * pitch));
        a = 0;
        b = 0;
        n = 0;
        while (n < lim) begin
            if (exceeds(mag_sq(a, b), radius * radius)) break;
            na = ((a * a - b * b) >>> met_pkg::FRAC_BITS) + cr;
            nb = ((a * b) >>> (met_pkg::FRAC_BITS - 1)) + ci;
            a = clamp32(na);
            b = clamp32(nb);
            n++;
        end
        p.col = col;
        p.row = row;
        p.in_set = !exceeds(mag_sq(a, b), 4);
        p.n = n[met_pkg::NW-1:0];
        g = 0;
        if (!p.in_set && lim != 0) g = (255 * n) / lim;
        p.green = g[7:0];
        p.blue = 8'((g * 3) / 5);
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch %s at result %0d: got %0d expected %0d", what, n_out, got, want);
    endtask

    // result side: random stall and compare
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 0);
                end else begin
                    pixel_t w;
                    w = pending_pixels.pop_front();
                    if (m_out_col !== w.col) report_mismatch("out_col", m_out_col, w.col);
                    if (m_out_row !== w.row) report_mismatch("out_row", m_out_row, w.row);
                    if (m_inside_res !== w.in_set)
                        report_mismatch("inside_res", m_inside_res, w.in_set);
                    if (m_iter_count !== w.n) report_mismatch("iter_count", m_iter_count, w.n);
                    if (m_green !== w.green) report_mismatch("green", m_green, w.green);
                    if (m_blue !== w.blue) report_mismatch("blue", m_blue, w.blue);
                    if (w.in_set) n_inside++;
                end
                n_out++;
            end
            m_ready <= ($urandom_range(99) >= idle_pct_m);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 200000) begin
            $display("watchdog expired");
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [met_pkg::CFG_IDX_W-1:0] idx,
                             input logic [met_pkg::CW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            met_pkg::REG_MIN_RE: re0 = $signed(64'($signed(val)));
            met_pkg::REG_MAX_IM: im0 = $signed(64'($signed(val)));
            met_pkg::REG_STEP: pitch = 64'(val[met_pkg::STEP_W-1:0]);
            met_pkg::REG_MAX_ITER: iter_max = 64'(val[met_pkg::NW-1:0]);
            met_pkg::REG_ESC_RAD: radius = 64'(val[met_pkg::ER_W-1:0]);
            default: begin
            end
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [met_pkg::PW-1:0] col,
                              input logic [met_pkg::PW-1:0] row);
        if ($urandom_range(99) < idle_pct_s) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct_s) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_col <= col;
        s_row <= row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_pixels.push_back(escape_pixel(col, row));
        n_in++;
    endtask

    task automatic set_view(input logic [met_pkg::CW-1:0] r, input logic [met_pkg::CW-1:0] i,
                            input logic [met_pkg::CW-1:0] s, input logic [met_pkg::CW-1:0] m,
                            input logic [met_pkg::CW-1:0] e);
        drain();
        write_reg(met_pkg::REG_MIN_RE, r);
        write_reg(met_pkg::REG_MAX_IM, i);
        write_reg(met_pkg::REG_STEP, s);
        write_reg(met_pkg::REG_MAX_ITER, m);
        write_reg(met_pkg::REG_ESC_RAD, e);
        cfg_we <= 1'b0;
    endtask

    vec_t table_rows[$];
    vec_t v;
    pixel_t k;

    initial begin
        re0 = -64'sd402653184;
        im0 = 64'sd402653184;
        pitch = 786432;
        iter_max = 256;
        radius = 2;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows with default view; far corner escapes after one iteration
        k = '{col: 11'd2047, row: 11'd2047, in_set: 1'b0, n: 11'd1, green: 8'd0, blue: 8'd0};
        table_rows.push_back('{11'd0, 11'd0, 1'b0, '0});
        table_rows.push_back('{11'd512, 11'd512, 1'b0, '0});
        table_rows.push_back('{11'd2047, 11'd0, 1'b0, '0});
        table_rows.push_back('{11'd0, 11'd2047, 1'b0, '0});
        table_rows.push_back('{11'd2047, 11'd2047, 1'b1, k});
        table_rows.push_back('{11'd1365, 11'd1024, 1'b0, '0});
        table_rows.push_back('{11'd1, 11'd1, 1'b0, '0});
        table_rows.push_back('{11'd1024, 11'd600, 1'b0, '0});
        foreach (table_rows[j]) begin
            v = table_rows[j];
            send_pixel(v.col, v.row);
            if (v.known) pending_pixels[$] = v.res;
        end
        // iteration limit zero: always inside with no steps
        set_view(32'hE8000000, 32'h18000000, 32'd786432, 32'd0, 32'd2);
        k = '{col: 11'd2047, row: 11'd2047, in_set: 1'b1, n: 11'd0, green: 8'd0, blue: 8'd0};
        send_pixel(11'd2047, 11'd2047);
        pending_pixels[$] = k;
        send_pixel(11'd3, 11'd5);
        // saturated corners, step zero, radius extremes, limit above maximum
        set_view(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd2047, 32'd7);
        send_pixel(11'd0, 11'd0);
        send_pixel(11'd2047, 11'd2047);
        set_view(32'h7FFFFFFF, 32'h80000000, 32'd0, 32'd1024, 32'd0);
        send_pixel(11'd0, 11'd0);
        send_pixel(11'd2047, 11'd1);
        set_view(32'hF0000000, 32'h00000000, 32'd0, 32'd1, 32'd0);
        send_pixel(11'd100, 11'd100);
        set_view(32'hF0000000, 32'h00000000, 32'd0, 32'd1, 32'd7);
        send_pixel(11'd100, 11'd100);
        set_view(32'h00000000, 32'h00000000, 32'd0, 32'd1024, 32'd2);
        send_pixel(11'd5, 11'd5);

        // random phases over several views and idle profiles
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct_s = 0;  idle_pct_m = 0;  end
                1: begin idle_pct_s = 74; idle_pct_m = 0;  end
                2: begin idle_pct_s = 0;  idle_pct_m = 74; end
                default: begin idle_pct_s = 8; idle_pct_m = 8; end
            endcase
            if (ph == 0)
                set_view(32'hE8000000, 32'h18000000, 32'd786432, 32'd256, 32'd2);
            else
                set_view(32'hE0000000 + $urandom_range(32'h08000000),
                         32'h08000000 + $urandom_range(32'h10000000),
                         $urandom_range(32'd4000000, 32'd100),
                         $urandom_range(ph == 7 ? 1024 : 64, 1),
                         $urandom_range(7));
            for (int j = 0; j < 205; j++) begin
                if (j % 5 == 0) send_pixel(met_pkg::PW'($urandom), met_pkg::PW'($urandom));
                else send_pixel(met_pkg::PW'($urandom_range(1023)),
                                met_pkg::PW'($urandom_range(1023)));
                if (j == 100) drain();
            end
        end
        drain();
        $display("sent %0d pixels, checked %0d results (%0d inside)", n_in, n_out, n_inside);
        $display("covered limit and radius extremes, saturated c, zero step, four idle profiles");
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/met_pkg.sv
rtl/met_cgen.sv
rtl/met_ring.sv
rtl/met_color.sv
rtl/mandelbrot_escape_time_pixel.sv
verif/tb_mandelbrot_escape_time_pixel.sv
